### rtl/flrmc_pkg.sv
// Package with the shared constants, command codes and rotate helper of the checksum core.
package flrmc_pkg;

  localparam int unsigned LANES      = 4;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CNT_W      = 4;
  localparam logic [CNT_W-1:0] MAX_BYTES = 4'd15;

  localparam logic [WORD_W-1:0] PREFIX_SEED = 32'h9e3779b9;
  localparam logic [WORD_W-1:0] FIN_MUL1    = 32'h85ebca6b;
  localparam logic [WORD_W-1:0] FIN_MUL2    = 32'hc2b2ae35;

  localparam logic [WORD_W-1:0] SEED_XOR [LANES] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5
  };
  localparam logic [WORD_W-1:0] SEED_ADD [LANES] = '{
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5
  };

  // Item commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_PREFIX = 2'd0,
    CMD_WORD   = 2'd1,
    CMD_TAIL   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Rotate left by a fixed amount.
  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                             input int unsigned s);
    rotl = (v << s) | (v >> (WORD_W - s));
  endfunction

endpackage

### rtl/flrmc_lane.sv
// One mixing lane: holds one element of each accumulator and folds in one word element.
module flrmc_lane
  import flrmc_pkg::*;
#(
  parameter int unsigned LANE = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clear,
  input  logic              word_en,
  input  logic              load_en,
  input  logic [WORD_W-1:0] load_val,
  input  logic [WORD_W-1:0] word,
  output logic [WORD_W-1:0] mix_nxt
);

  logic [WORD_W-1:0] xor_lane_r, xor_lane_nxt;
  logic [WORD_W-1:0] add_lane_r, add_lane_nxt;
  logic [WORD_W-1:0] rot_a;
  logic [WORD_W-1:0] sum_c;

  // Word mixing: xor then rotate left 5; add, xor, rotate right 13.
  assign rot_a = rotl(xor_lane_r ^ word, 5);
  assign sum_c = (add_lane_r + word) ^ rot_a;

  always_comb begin
    xor_lane_nxt = xor_lane_r;
    add_lane_nxt = add_lane_r;
    if (word_en) begin
      xor_lane_nxt = rot_a;
      add_lane_nxt = rotl(sum_c, 19);
    end else if (load_en) begin
      xor_lane_nxt = load_val;
    end
  end

  // Combined value of this lane after the current transfer, for the merge.
  assign mix_nxt = xor_lane_nxt ^ add_lane_nxt;

  // Lane registers return to their seeds on reset and at the end of a run.
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      xor_lane_r <= SEED_XOR[LANE];
      add_lane_r <= SEED_ADD[LANE];
    end else begin
      xor_lane_r <= xor_lane_nxt;
      add_lane_r <= add_lane_nxt;
    end
  end

endmodule

### rtl/flrmc_merge.sv
// Merge stage: xor-reduces the combined values of all lanes.
module flrmc_merge
  import flrmc_pkg::*;
(
  input  logic [WORD_W-1:0] lane_mix [LANES],
  output logic [WORD_W-1:0] reduced
);

  // Xor chain over the lanes.
  always_comb begin
    reduced = '0;
    for (int unsigned i = 0; i < LANES; i++) begin
      reduced = reduced ^ lane_mix[i];
    end
  end

endmodule

### rtl/flrmc_final.sv
// Finalizer: three-step avalanche mix with a registered result and valid/ready output.
module flrmc_final
  import flrmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] value,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_checksum
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MIX1 = 5'b00010,
    F_MIX2 = 5'b00100,
    F_FOLD = 5'b01000,
    F_OUT  = 5'b10000
  } fin_state_t;

  fin_state_t        state_r, state_nxt;
  logic [WORD_W-1:0] data_r, data_nxt;
  logic [WORD_W-1:0] mix_in;
  logic [2*WORD_W-1:0] product;

  // Shared mixing path: pick the shift and multiplier for the current step.
  always_comb begin
    mix_in  = data_r ^ (data_r >> 16);
    product = {2*WORD_W{1'b0}};
    unique case (state_r)
      F_MIX1: product = mix_in * FIN_MUL1;
      F_MIX2: product = (data_r ^ (data_r >> 13)) * FIN_MUL2;
      default: product = {2*WORD_W{1'b0}};
    endcase
  end

  // Step sequencer.
  always_comb begin
    state_nxt = state_r;
    data_nxt  = data_r;
    unique case (state_r)
      F_IDLE: begin
        if (start) begin
          state_nxt = F_MIX1;
          data_nxt  = value;
        end
      end
      F_MIX1: begin
        state_nxt = F_MIX2;
        data_nxt  = product[WORD_W-1:0];
      end
      F_MIX2: begin
        state_nxt = F_FOLD;
        data_nxt  = product[WORD_W-1:0];
      end
      F_FOLD: begin
        state_nxt = F_OUT;
        data_nxt  = mix_in;
      end
      F_OUT: begin
        if (out_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign busy         = (state_r != F_IDLE);
  assign out_valid    = (state_r == F_OUT);
  assign out_checksum = data_r;

endmodule

### rtl/four_lane_rotate_mix_checksum_core.sv
// Top level of the four-lane rotate-mix chunk checksum core.
//
//   channel | ports                                               | direction
//   --------+-----------------------------------------------------+----------
//   input   | in_valid in_ready in_cmd in_byte_value in_word0..3  | in
//           | in_last                                             |
//   result  | out_valid out_ready out_checksum                    | out
//
// A prefix, word or tail item is taken when in_valid and in_ready are both high; the four lanes mix a word
// in parallel and the merge tree reduces them in the same cycle.
// An item marked last hands its value to the finalizer, which runs two registered
// 32x32 multiplies and a fold before the checksum is offered.
// in_ready is low after the transfer of a last item until its checksum has been taken,
// so no new item is taken while the finalizer works or its output stalls.
// Reset is synchronous and active low and returns every lane to its seed.
module four_lane_rotate_mix_checksum_core
  import flrmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [BYTE_W-1:0] in_byte_value,
  input  logic [WORD_W-1:0] in_word0,
  input  logic [WORD_W-1:0] in_word1,
  input  logic [WORD_W-1:0] in_word2,
  input  logic [WORD_W-1:0] in_word3,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_checksum
);

  logic              fin_busy;
  logic              in_xfer;
  logic              prefix_ok, word_ok, tail_ok;
  logic              take, finish;
  logic [CNT_W-1:0]  prefix_count_r, tail_count_r;
  logic              words_seen_r, tail_seen_r;
  logic [WORD_W-1:0] prefix_hash_r, prefix_hash_nxt;
  logic [WORD_W-1:0] tail_hash_r, tail_hash_nxt;
  logic [WORD_W-1:0] tail_base;
  logic [WORD_W-1:0] reduced;
  logic [WORD_W-1:0] run_value;
  logic [WORD_W-1:0] lane_word [LANES];
  logic [WORD_W-1:0] lane_mix [LANES];
  cmd_t              cmd;

  assign cmd      = cmd_t'(in_cmd);
  assign in_ready = !fin_busy;
  assign in_xfer  = in_valid && in_ready;

  // Order checks: items that break the prefix, word, tail order, NONE items and bytes past MAX_BYTES are dropped.
  assign prefix_ok = in_xfer && (cmd == CMD_PREFIX) && !words_seen_r && !tail_seen_r &&
                     (prefix_count_r != MAX_BYTES);
  assign word_ok   = in_xfer && (cmd == CMD_WORD) && !tail_seen_r;
  assign tail_ok   = in_xfer && (cmd == CMD_TAIL) && (tail_count_r != MAX_BYTES);
  assign take      = prefix_ok || word_ok || tail_ok;
  assign finish    = take && in_last;

  // Prefix and tail byte hashes.
  assign prefix_hash_nxt = rotl(prefix_hash_r, 5) ^ {{(WORD_W-BYTE_W){1'b0}}, in_byte_value};
  assign tail_base       = tail_seen_r ? tail_hash_r : reduced;
  assign tail_hash_nxt   = rotl(tail_base, 7) ^ {{(WORD_W-BYTE_W){1'b0}}, in_byte_value};

  assign lane_word[0] = in_word0;
  assign lane_word[1] = in_word1;
  assign lane_word[2] = in_word2;
  assign lane_word[3] = in_word3;

  // Parallel mixing lanes; only lane 0 takes the prefix hash.
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    flrmc_lane #(
      .LANE(g)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .clear   (finish),
      .word_en (word_ok),
      .load_en (prefix_ok && (g == 0)),
      .load_val(prefix_hash_nxt),
      .word    (lane_word[g]),
      .mix_nxt (lane_mix[g])
    );
  end

  flrmc_merge u_merge (
    .lane_mix(lane_mix),
    .reduced (reduced)
  );

  // Value handed to the finalizer at the end of a run.
  always_comb begin
    priority if (tail_ok) begin
      run_value = tail_hash_nxt;
    end else if (tail_seen_r) begin
      run_value = tail_hash_r;
    end else begin
      run_value = reduced;
    end
  end

  // Run bookkeeping; everything returns to reset after a finished run.
  always_ff @(posedge clk) begin
    if (!rst_n || finish) begin
      prefix_count_r <= '0;
      tail_count_r   <= '0;
      words_seen_r   <= 1'b0;
      tail_seen_r    <= 1'b0;
      prefix_hash_r  <= PREFIX_SEED;
      tail_hash_r    <= '0;
    end else begin
      if (prefix_ok) begin
        prefix_count_r <= prefix_count_r + 1'b1;
        prefix_hash_r  <= prefix_hash_nxt;
      end
      if (word_ok) begin
        words_seen_r <= 1'b1;
      end
      if (tail_ok) begin
        tail_count_r <= tail_count_r + 1'b1;
        tail_seen_r  <= 1'b1;
        tail_hash_r  <= tail_hash_nxt;
      end
    end
  end

  flrmc_final u_final (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (finish),
    .value       (run_value),
    .busy        (fin_busy),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_checksum(out_checksum)
  );

endmodule
